FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl of the deframer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// shared types and constants of the length-prefixed crc-32 deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cld_pkg;

    // reflected crc-32 (ieee)
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

    // reset value of the maximum payload register
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4096;

    // frame status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK = 2'd0;
    localparam status_t STATUS_TOO_LONG = 2'd1;
    localparam status_t STATUS_CRC_ERR = 2'd2;

    // result of one input item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_end;
        status_t     frame_status;
        logic [31:0] frame_length;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/cld_crc8.sv
// ----------------------------------------------------------------------------
// cld_crc8
// one byte step of the reflected crc-32, lsb first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cld_crc8 (
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic [31:0]      crc_out
);
    import cld_pkg::*;

    // eight shift-and-reduce steps folded into one xor network
    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

FILE: rtl/cld_parser.sv
// ----------------------------------------------------------------------------
// cld_parser
// frame state, header capture, crc check and result forming for one byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cld_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        item_valid,
    input  wire logic [7:0]  rx_byte,
    output cld_pkg::res_t    res
);
    import cld_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN = 2'd0,
        PH_CRC = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] length_value_reg, length_value_next;
    logic [31:0] expected_crc_reg, expected_crc_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] max_payload_reg;

    logic [31:0] hdr_count;
    logic [31:0] lane;
    logic [31:0] len_word;
    logic [31:0] crc_word;
    logic [31:0] count_inc;
    logic [31:0] crc_upd;

    // byte-wide crc update of the running value
    cld_crc8 u_crc8 (
        .crc_in  (running_crc_reg),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    // header byte position and lane placement, little endian
    always_comb
    begin
        hdr_count = (phase_reg == PH_CRC || phase_reg == PH_LEN) ? byte_count_reg : 32'd0;
        lane      = {24'd0, rx_byte} << {hdr_count[1:0], 3'b000};
        len_word  = ((hdr_count == 32'd0) ? 32'd0 : length_value_reg) | lane;
        crc_word  = expected_crc_reg | lane;
        count_inc = byte_count_reg + 32'd1;
    end

    // next state and result
    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        length_value_next = length_value_reg;
        expected_crc_next = expected_crc_reg;
        running_crc_next  = running_crc_reg;
        res               = '0;

        unique case (phase_reg)
            PH_CRC:
            begin
                expected_crc_next = crc_word;
                if (byte_count_reg >= 32'd3)
                begin
                    byte_count_next = 32'd0;
                    if (length_value_reg == 32'd0)
                    begin
                        // empty payload ends the frame on the last crc byte
                        res.frame_end    = 1'b1;
                        res.frame_status = (crc_word == 32'd0) ? STATUS_OK : STATUS_CRC_ERR;
                        phase_next       = PH_LEN;
                    end
                    else
                    begin
                        running_crc_next = CRC_INIT;
                        phase_next       = PH_PAY;
                    end
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
            PH_PAY:
            begin
                res.payload_byte  = rx_byte;
                res.payload_valid = 1'b1;
                running_crc_next  = crc_upd;
                byte_count_next   = count_inc;
                if (count_inc >= length_value_reg)
                begin
                    res.frame_end    = 1'b1;
                    res.frame_status = ((crc_upd ^ CRC_XOROUT) == expected_crc_reg) ?
                                       STATUS_OK : STATUS_CRC_ERR;
                    res.frame_length = length_value_reg;
                    byte_count_next  = 32'd0;
                    phase_next       = PH_LEN;
                end
            end
            default:
            begin
                // length header, also the recovery path for the unused code
                phase_next        = PH_LEN;
                length_value_next = len_word;
                if (hdr_count >= 32'd3)
                begin
                    byte_count_next = 32'd0;
                    if (len_word > max_payload_reg)
                    begin
                        res.frame_end    = 1'b1;
                        res.frame_status = STATUS_TOO_LONG;
                        res.frame_length = len_word;
                    end
                    else
                    begin
                        expected_crc_next = 32'd0;
                        phase_next        = PH_CRC;
                    end
                end
                else
                begin
                    byte_count_next = hdr_count + 32'd1;
                end
            end
        endcase
    end

    // frame state, advanced once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEN;
            byte_count_reg   <= 32'd0;
            length_value_reg <= 32'd0;
            expected_crc_reg <= 32'd0;
            running_crc_reg  <= CRC_INIT;
        end
        else if (item_valid)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            length_value_reg <= length_value_next;
            expected_crc_reg <= expected_crc_next;
            running_crc_reg  <= running_crc_next;
        end
    end

    // maximum payload register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

    // checks
    `ASSERT_IMPLIES(a_pay_count, clk, rst_n, phase_reg == PH_PAY, byte_count_reg < length_value_reg)
    `ASSERT_IMPLIES(a_too_long, clk, rst_n, res.frame_status == STATUS_TOO_LONG, res.frame_length > max_payload_reg)
    `ASSERT_NEXT(a_end_to_len, clk, rst_n, item_valid && res.frame_end, phase_reg == PH_LEN)
    `ASSERT_IMPLIES(a_pay_flag, clk, rst_n, phase_reg == PH_PAY, res.payload_valid)

endmodule

`default_nettype wire

FILE: rtl/crc32_length_prefixed_deframer_top.sv
// flow: an accepted item is held in the input register, and its result is
//   registered in the result register, from which it leaves
// throughput: one byte per cycle while the result side is not stalled; the
//   limit is the single byte-wide crc step
// reset: rst_n clears the frame state to awaiting a length header, empties
//   both registers and sets max_payload to 4096
// ----------------------------------------------------------------------------
// crc32_length_prefixed_deframer_top
// length-prefixed frame deframer with crc-32 check on a byte stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module crc32_length_prefixed_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: max_payload
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    // received stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] payload_byte, [39:8] frame_length
    output logic             m_axis_tlast,   // frame_end
    output logic [2:0]       m_axis_tuser    // [0] payload_valid, [2:1] frame_status
);
    import cld_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    res_t       parse_res;
    logic       out_ready;
    logic       advance;

    // handshake between the two registers
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    // frame parser on the registered byte
    cld_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (advance),
        .rx_byte    (in_byte_reg),
        .res        (parse_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= parse_res;
        end
    end

    // result packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.frame_length, out_res_reg.payload_byte};
    assign m_axis_tlast  = out_res_reg.frame_end;
    assign m_axis_tuser  = {out_res_reg.frame_status, out_res_reg.payload_valid};

    // checks
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !out_ready,
        in_valid_reg && $stable(in_byte_reg))
    `ASSERT_IMPLIES(a_mid_frame, clk, rst_n, m_axis_tvalid && !m_axis_tlast,
        m_axis_tuser[2:1] == STATUS_OK && m_axis_tdata[39:8] == 32'd0)
    `ASSERT_IMPLIES(a_pay_status, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tuser[2:1] != STATUS_TOO_LONG)
    `ASSERT_ALWAYS(a_status_code, clk, rst_n, !m_axis_tvalid || m_axis_tuser[2:1] != 2'b11)

endmodule

`default_nettype wire
